// File: design/positional_list_store_assert.svh
// Assertion macros shared by the checker of the positional list store.
// No dependencies; include once per file that asserts.
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// same-cycle implication
`define PLS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("positional_list_store: assertion failed");

// next-cycle implication
`define PLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("positional_list_store: assertion failed");

`endif

// File: design/pls_pkg.sv
// Shared types and codes for the positional list store.
// No dependencies.
package pls_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int POS_W            = 8;
   localparam int VALUE_W          = 32;

   // request commands
   localparam logic [2:0] CMD_FRONT_INSERT = 3'd0;
   localparam logic [2:0] CMD_APPEND       = 3'd1;
   localparam logic [2:0] CMD_INSERT_AT    = 3'd2;
   localparam logic [2:0] CMD_REMOVE_FRONT = 3'd3;
   localparam logic [2:0] CMD_REMOVE_BACK  = 3'd4;
   localparam logic [2:0] CMD_REMOVE_AT    = 3'd5;
   localparam logic [2:0] CMD_DUMP         = 3'd6;
   localparam logic [2:0] CMD_DUMP_REV     = 3'd7;

   // result status
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   // cell modes broadcast along the chain
   typedef logic [2:0] pls_mode_type;
   localparam pls_mode_type MODE_HOLD    = 3'd0;
   localparam pls_mode_type MODE_INSERT  = 3'd1;
   localparam pls_mode_type MODE_REMOVE  = 3'd2;
   localparam pls_mode_type MODE_ROT_FWD = 3'd3;
   localparam pls_mode_type MODE_ROT_REV = 3'd4;

   typedef struct packed {
      pls_mode_type     mode;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] count;
   } pls_bcast_type;

endpackage

// File: design/pls_cell.sv
// One storage cell of the list chain: holds an entry, loads, or takes a neighbor.
// Depends on pls_pkg.
module pls_cell #(
   parameter int INDEX = 0
) (
   input  logic                          clock,
   input  pls_pkg::pls_bcast_type        bcast,
   input  logic [pls_pkg::VALUE_W-1:0]   load_value,
   input  logic [pls_pkg::VALUE_W-1:0]   prev_value,
   input  logic [pls_pkg::VALUE_W-1:0]   next_value,
   output logic [pls_pkg::VALUE_W-1:0]   value
);
   import pls_pkg::*;

   localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      unique case (bcast.mode)
         MODE_INSERT: begin
            if (IDX > bcast.pos) value_in = prev_value;
            else if (IDX == bcast.pos) value_in = load_value;
         end
         MODE_REMOVE: begin
            if (IDX >= bcast.pos) value_in = next_value;
         end
         MODE_ROT_FWD: begin
            if (IDX < bcast.count) value_in = next_value;
         end
         MODE_ROT_REV: begin
            if (IDX < bcast.count) value_in = prev_value;
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// File: design/positional_list_store.sv
// Top level of the positional list store: command control and the cell chain.
// Depends on pls_pkg and pls_cell.
//
//  channel   | transfer when        | ports
//  ----------+----------------------+------------------------------------------
//  request   | start && !busy       | req_command, req_item_value, req_position
//  result    | rsp_valid (1 cycle)  | rsp_entry_value, rsp_has_entry,
//            |                      | rsp_status, rsp_last
//
//  Edits shift all cells at once, and the result shows the next cycle.
//  A dump of N entries rotates the chain once per entry while busy stays high,
//  one result per cycle, and the chain is back in order when the dump ends.
//  An empty dump answers like an edit, with an empty status.
//  Synchronous reset empties the list at once; the cells themselves are not cleared.
//  The receiver cannot stall, so results never wait.
module positional_list_store #(
   parameter int CAPACITY = pls_pkg::DEFAULT_CAPACITY
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [2:0]                         req_command,
   input  logic signed [pls_pkg::VALUE_W-1:0] req_item_value,
   input  logic [pls_pkg::POS_W-1:0]          req_position,
   output logic                               rsp_valid,
   output logic signed [pls_pkg::VALUE_W-1:0] rsp_entry_value,
   output logic                               rsp_has_entry,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_last
);
   import pls_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam logic [CW-1:0] CAP = CW'(CAPACITY);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_DUMP = 1'b1;

   logic          state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] remain_ff, remain_in;
   logic          rev_ff, rev_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_has_ff, rsp_has_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   pls_bcast_type      bcast;
   logic [VALUE_W-1:0] cell_value [CAPACITY];
   logic [VALUE_W-1:0] prev_value [CAPACITY];
   logic [VALUE_W-1:0] next_value [CAPACITY];
   logic [VALUE_W-1:0] tail_value;
   logic [CW-1:0]      tail_cnt;
   logic [IW-1:0]      tail_idx;
   logic [POS_W-1:0]   count_w;
   logic [POS_W-1:0]   edit_pos;
   logic               accept;

   assign accept   = start && (state_ff == S_IDLE);
   assign count_w  = POS_W'(count_ff);
   assign tail_cnt = count_ff - CW'(1);
   assign tail_idx = tail_cnt[IW-1:0];
   assign tail_value = cell_value[tail_idx];

   always_comb begin
      unique case (req_command)
         CMD_FRONT_INSERT, CMD_REMOVE_FRONT: edit_pos = '0;
         CMD_APPEND:                         edit_pos = count_w;
         CMD_REMOVE_BACK:                    edit_pos = POS_W'(tail_cnt);
         default:                            edit_pos = req_position;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      remain_in     = remain_ff;
      rev_in        = rev_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = '0;
      rsp_has_in    = 1'b0;
      rsp_status_in = ST_DONE;
      rsp_last_in   = 1'b1;
      bcast.mode    = MODE_HOLD;
      bcast.pos     = edit_pos;
      bcast.count   = count_w;

      if (state_ff == S_DUMP) begin
         // emit the head (the tail when reversed), rotate so the next one takes its place
         rsp_valid_in = 1'b1;
         rsp_has_in   = 1'b1;
         rsp_value_in = rev_ff ? tail_value : cell_value[0];
         rsp_last_in  = (remain_ff == CW'(1));
         bcast.mode   = rev_ff ? MODE_ROT_REV : MODE_ROT_FWD;
         remain_in    = remain_ff - CW'(1);
         if (remain_ff == CW'(1)) state_in = S_IDLE;
      end else if (accept) begin
         rsp_valid_in = 1'b1;
         unique case (req_command)
            CMD_FRONT_INSERT, CMD_APPEND, CMD_INSERT_AT: begin
               if (edit_pos > count_w) begin
                  rsp_status_in = ST_RANGE;
               end else if (count_ff >= CAP) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  bcast.mode = MODE_INSERT;
                  count_in   = count_ff + CW'(1);
               end
            end
            CMD_REMOVE_FRONT, CMD_REMOVE_BACK, CMD_REMOVE_AT: begin
               if (count_ff == '0) begin
                  rsp_status_in = ST_EMPTY;
               end else if (edit_pos >= count_w) begin
                  rsp_status_in = ST_RANGE;
               end else begin
                  bcast.mode = MODE_REMOVE;
                  count_in   = count_ff - CW'(1);
               end
            end
            default: begin
               if (count_ff == '0) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  // hold off the result; the dump state emits every entry
                  rsp_valid_in = 1'b0;
                  state_in     = S_DUMP;
                  remain_in    = count_ff;
                  rev_in       = (req_command == CMD_DUMP_REV);
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rev_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rev_ff       <= rev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      // wrap the chain ends so rotations close the ring over the live entries
      if (i == 0) begin : g_first
         assign prev_value[i] = tail_value;
      end else begin : g_rest
         assign prev_value[i] = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_end
         assign next_value[i] = cell_value[0];
      end else begin : g_mid
         assign next_value[i] = (tail_cnt == CW'(i)) ? cell_value[0] : cell_value[i+1];
      end

      pls_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .bcast      (bcast),
         .load_value (req_item_value),
         .prev_value (prev_value[i]),
         .next_value (next_value[i]),
         .value      (cell_value[i])
      );
   end

   assign busy            = (state_ff == S_DUMP);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_has_entry   = rsp_has_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// File: design/pls_checker.sv
// Port-level checks of the positional list store, bound to the top level.
// Depends on pls_pkg, positional_list_store_assert.svh and positional_list_store.
`include "positional_list_store_assert.svh"

module pls_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic [2:0]                         req_command,
   input logic                               rsp_valid,
   input logic signed [pls_pkg::VALUE_W-1:0] rsp_entry_value,
   input logic                               rsp_has_entry,
   input logic [1:0]                         rsp_status,
   input logic                               rsp_last
);
   import pls_pkg::*;

   logic edit_accept;
   assign edit_accept = start && !busy &&
                        (req_command != CMD_DUMP) && (req_command != CMD_DUMP_REV);

   `PLS_ASSERT_NEXT(a_edit_result, clock, reset, edit_accept, rsp_valid && rsp_last && !rsp_has_entry)
   `PLS_ASSERT_NEXT(a_dump_emits, clock, reset, busy, rsp_valid && rsp_has_entry)
   `PLS_ASSERT_IMPLY(a_status_only, clock, reset, rsp_valid && !rsp_has_entry, rsp_last && (rsp_entry_value == 0))
   `PLS_ASSERT_IMPLY(a_entry_done, clock, reset, rsp_valid && rsp_has_entry, rsp_status == ST_DONE)

endmodule

bind positional_list_store pls_checker u_pls_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_command     (req_command),
   .rsp_valid       (rsp_valid),
   .rsp_entry_value (rsp_entry_value),
   .rsp_has_entry   (rsp_has_entry),
   .rsp_status      (rsp_status),
   .rsp_last        (rsp_last)
);
